[rtl/core/assert_macros.svh]
// Assertion macros for the checker file mec_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MEC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/core/mec_pkg.sv]
// Types, constants and a helper function for the escape-time counter.
`default_nettype none

package mec_pkg;

  localparam int IDX_W  = 12;
  localparam int CRD_W  = 32;
  localparam int STEP_W = 24;
  localparam int ITER_W = 16;
  localparam int CNT_W  = 25;
  localparam int PROD_W = 64;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int Q_FRAC = 28;

  localparam logic [2:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [2:0] REG_ORIGIN_IM = 3'd1;
  localparam logic [2:0] REG_STEP_RE   = 3'd2;
  localparam logic [2:0] REG_STEP_IM   = 3'd3;
  localparam logic [2:0] REG_MAX_ITER  = 3'd4;

  localparam logic signed [CRD_W-1:0] ORIGIN_RE_RST = 32'shE000_001B;
  localparam logic signed [CRD_W-1:0] ORIGIN_IM_RST = 32'sd27;
  localparam logic [STEP_W-1:0]       STEP_RE_RST   = 24'd335544;
  localparam logic [STEP_W-1:0]       STEP_IM_RST   = 24'd150995;
  localparam logic [ITER_W-1:0]       MAX_ITER_RST  = 16'd2000;

  // |z|^2 threshold of 4.0 on Q8.56 squares
  localparam logic [PROD_W-1:0] ESC_LIMIT = 64'h0400_0000_0000_0000;
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

  typedef struct packed {
    logic [IDX_W-1:0] col_index;
    logic [IDX_W-1:0] row_index;
    logic             first_point;
  } mec_in_t;

  typedef struct packed {
    logic              escaped;
    logic [ITER_W-1:0] iterations_used;
    logic [CNT_W-1:0]  escape_count;
  } mec_out_t;

  function automatic logic signed [CRD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      return 32'sh8000_0000;
    end
    return signed'(v[CRD_W-1:0]);
  endfunction

endpackage

`default_nettype wire

[rtl/core/mec_index_mod.sv]
// Reduction of the column and row indexes modulo the grid side by reciprocal multiply.
`default_nettype none

module mec_index_mod import mec_pkg::*; #(
  parameter int GRID_SIDE = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [IDX_W-1:0] col_in,
  input  wire logic [IDX_W-1:0] row_in,
  output logic                  busy,
  output logic [IDX_W-1:0]      col_out,
  output logic [IDX_W-1:0]      row_out
);

  localparam int RCP_S = 2 * IDX_W;
  localparam int PRD_W = IDX_W + RCP_S + 1;
  localparam int BCK_W = 2 * IDX_W + 1;
  localparam logic [IDX_W:0] GS = (IDX_W + 1)'(GRID_SIDE);
  // ceil(2^RCP_S / GRID_SIDE), exact quotient for every IDX_W-bit index
  localparam logic [RCP_S:0] RCP_M =
    (RCP_S + 1)'(((longint'(1) << RCP_S) + longint'(GRID_SIDE) - longint'(1))
                 / longint'(GRID_SIDE));

  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] col_src_r, col_src_nxt;
  logic [IDX_W-1:0] row_src_r, row_src_nxt;
  logic [IDX_W-1:0] col_rem_r, col_rem_nxt;
  logic [IDX_W-1:0] row_rem_r, row_rem_nxt;

  function automatic logic [IDX_W-1:0] mod_grid(input logic [IDX_W-1:0] x);
    logic [PRD_W-1:0] prod;
    logic [IDX_W-1:0] quo;
    logic [BCK_W-1:0] back;
    prod = PRD_W'(x) * PRD_W'(RCP_M);
    quo  = prod[RCP_S +: IDX_W];
    back = BCK_W'(quo) * BCK_W'(GS);
    return x - back[IDX_W-1:0];
  endfunction

  always_comb begin
    pend_nxt    = start;
    col_src_nxt = col_src_r;
    row_src_nxt = row_src_r;
    if (start) begin
      col_src_nxt = col_in;
      row_src_nxt = row_in;
    end
    col_rem_nxt = mod_grid(col_src_r);
    row_rem_nxt = mod_grid(row_src_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
    col_src_r <= col_src_nxt;
    row_src_r <= row_src_nxt;
    col_rem_r <= col_rem_nxt;
    row_rem_r <= row_rem_nxt;
  end

  assign busy    = pend_r;
  assign col_out = col_rem_r;
  assign row_out = row_rem_r;

endmodule

`default_nettype wire

[rtl/core/mandelbrot_escape_counter.sv]
// One point at a time: in_stall stays high from the accepting edge until the result
// is loaded into the output register; the next point can be taken the cycle after.
// Iteration states SQR, SQI, CHK, UPD share the single 32x32 multiplier (3 products).
// Index reduction is a registered reciprocal-multiply unit (indexes, then remainders).
// Reset (rst_n low, synchronous): config to defaults, count cleared, output empty.
`default_nettype none

module mandelbrot_escape_counter import mec_pkg::*; #(
  parameter int GRID_SIDE = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mec_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mec_out_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD  = 4'd1;
  localparam logic [3:0] S_CR   = 4'd2;
  localparam logic [3:0] S_CI   = 4'd3;
  localparam logic [3:0] S_LDI  = 4'd4;
  localparam logic [3:0] S_SQR  = 4'd5;
  localparam logic [3:0] S_SQI  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_r, state_nxt;

  logic signed [CRD_W-1:0] origin_re_r, origin_re_nxt;
  logic signed [CRD_W-1:0] origin_im_r, origin_im_nxt;
  logic [STEP_W-1:0]       step_re_r, step_re_nxt;
  logic [STEP_W-1:0]       step_im_r, step_im_nxt;
  logic [ITER_W-1:0]       max_iter_r, max_iter_nxt;

  logic [CNT_W-1:0]         total_r, total_nxt;
  logic signed [CRD_W-1:0]  cr_r, cr_nxt;
  logic signed [CRD_W-1:0]  ci_r, ci_nxt;
  logic signed [CRD_W-1:0]  zr_r, zr_nxt;
  logic signed [CRD_W-1:0]  zi_r, zi_nxt;
  logic signed [PROD_W-1:0] rr_r, rr_nxt;
  logic signed [PROD_W-1:0] ii_r, ii_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [ITER_W-1:0]        n_r, n_nxt;
  logic [ITER_W-1:0]        limit_r, limit_nxt;
  logic                     esc_r, esc_nxt;
  logic [ITER_W-1:0]        used_r, used_nxt;
  logic                     out_valid_r, out_valid_nxt;
  mec_out_t                 out_data_r, out_data_nxt;

  logic                     mod_start;
  logic                     mod_busy;
  logic [IDX_W-1:0]         col_mod;
  logic [IDX_W-1:0]         row_mod;

  logic signed [CRD_W-1:0]  mul_a;
  logic signed [CRD_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] coord_re;
  logic signed [PROD_W-1:0] coord_im;
  logic signed [PROD_W-1:0] nre;
  logic signed [PROD_W-1:0] nim;
  logic [PROD_W-1:0]        mag;
  logic                     mag_hit;
  logic [CNT_W-1:0]         total_upd;
  logic                     cfg_wr;

  mec_index_mod #(
    .GRID_SIDE(GRID_SIDE)
  ) u_index_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .col_in (in_data.col_index),
    .row_in (in_data.row_index),
    .busy   (mod_busy),
    .col_out(col_mod),
    .row_out(row_mod)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign mod_start = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  // shared multiplier
  always_comb begin
    unique case (state_r)
      S_CR: begin
        mul_a = signed'(CRD_W'(step_re_r));
        mul_b = signed'(CRD_W'(col_mod));
      end
      S_CI: begin
        mul_a = signed'(CRD_W'(step_im_r));
        mul_b = signed'(CRD_W'(row_mod));
      end
      S_SQR: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
      S_SQI: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      default: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign coord_re = PROD_W'(origin_re_r) + prod_r;
  assign coord_im = PROD_W'(origin_im_r) + prod_r;
  assign nre      = rr_r - ii_r + (PROD_W'(cr_r) <<< Q_FRAC);
  assign nim      = prod_r + (PROD_W'(ci_r) <<< (Q_FRAC - 1));
  assign mag      = unsigned'(rr_r) + unsigned'(prod_r);
  assign mag_hit  = (mag > ESC_LIMIT);
  assign total_upd = (esc_r && (total_r != CNT_MAX)) ? total_r + 1'b1 : total_r;

  always_comb begin
    unique case (paddr[4:2])
      REG_ORIGIN_RE: prdata = unsigned'(origin_re_r);
      REG_ORIGIN_IM: prdata = unsigned'(origin_im_r);
      REG_STEP_RE:   prdata = DATA_W'(step_re_r);
      REG_STEP_IM:   prdata = DATA_W'(step_im_r);
      REG_MAX_ITER:  prdata = DATA_W'(max_iter_r);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    origin_re_nxt = origin_re_r;
    origin_im_nxt = origin_im_r;
    step_re_nxt   = step_re_r;
    step_im_nxt   = step_im_r;
    max_iter_nxt  = max_iter_r;
    if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_ORIGIN_RE: origin_re_nxt = signed'(pwdata);
        REG_ORIGIN_IM: origin_im_nxt = signed'(pwdata);
        REG_STEP_RE:   step_re_nxt   = pwdata[STEP_W-1:0];
        REG_STEP_IM:   step_im_nxt   = pwdata[STEP_W-1:0];
        REG_MAX_ITER:  max_iter_nxt  = pwdata[ITER_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    rr_nxt        = rr_r;
    ii_nxt        = ii_r;
    n_nxt         = n_r;
    limit_nxt     = limit_r;
    esc_nxt       = esc_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.first_point) begin
            total_nxt = '0;
          end
          limit_nxt = (max_iter_r == '0) ? ITER_W'(1) : max_iter_r;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (!mod_busy) begin
          state_nxt = S_CR;
        end
      end
      S_CR: begin
        state_nxt = S_CI;
      end
      S_CI: begin
        cr_nxt    = sat32(coord_re);
        zr_nxt    = sat32(coord_re);
        state_nxt = S_LDI;
      end
      S_LDI: begin
        ci_nxt    = sat32(coord_im);
        zi_nxt    = sat32(coord_im);
        n_nxt     = '0;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        state_nxt = S_SQI;
      end
      S_SQI: begin
        rr_nxt    = prod_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        ii_nxt = prod_r;
        if ((n_r != '0) && mag_hit) begin
          esc_nxt   = 1'b1;
          used_nxt  = n_r;
          state_nxt = S_DONE;
        end else if (n_r == limit_r) begin
          esc_nxt   = 1'b0;
          used_nxt  = limit_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        zr_nxt    = sat32(nre >>> Q_FRAC);
        zi_nxt    = sat32(nim >>> (Q_FRAC - 1));
        n_nxt     = n_r + 1'b1;
        state_nxt = S_SQR;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          total_nxt                    = total_upd;
          out_valid_nxt                = 1'b1;
          out_data_nxt.escaped         = esc_r;
          out_data_nxt.iterations_used = used_r;
          out_data_nxt.escape_count    = total_upd;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      origin_re_r <= ORIGIN_RE_RST;
      origin_im_r <= ORIGIN_IM_RST;
      step_re_r   <= STEP_RE_RST;
      step_im_r   <= STEP_IM_RST;
      max_iter_r  <= MAX_ITER_RST;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      origin_re_r <= origin_re_nxt;
      origin_im_r <= origin_im_nxt;
      step_re_r   <= step_re_nxt;
      step_im_r   <= step_im_nxt;
      max_iter_r  <= max_iter_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cr_r       <= cr_nxt;
    ci_r       <= ci_nxt;
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    rr_r       <= rr_nxt;
    ii_r       <= ii_nxt;
    prod_r     <= prod_nxt;
    n_r        <= n_nxt;
    limit_r    <= limit_nxt;
    esc_r      <= esc_nxt;
    used_r     <= used_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/mec_checker.sv]
// Port-level checks for the escape-time counter, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module mec_checker import mec_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire mec_out_t out_data
);

  // stalled result holds
  `MEC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one point in flight: busy right after a transaction
  `MEC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  `MEC_ASSERT_IMP(a_iter_nonzero, out_valid, out_data.iterations_used != '0)

  `MEC_ASSERT_IMP(a_count_on_escape, out_valid && out_data.escaped,
                  out_data.escape_count != '0)

endmodule

bind mandelbrot_escape_counter mec_checker u_mec_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire
